>>> rtl/mm64_pkg.sv
`timescale 1ns / 1ps

package mm64_pkg;

    // Multiply constant and shift of the MurmurHash64A mixing steps.
    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    // Halves of the multiply constant for the 32x32 partial products.
    localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];

    // Bytes in one full message word.
    localparam logic [3:0] WORD_BYTES = 4'd8;

    // Default depth of the command queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 2;

    // What the back end has to do with one word.
    typedef enum logic [1:0] {
        KIND_SKIP,
        KIND_TAIL,
        KIND_FULL
    } cmd_kind_t;

    // One classified word as it travels through the queue.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        cmd_kind_t   kind;
        logic        first;
        logic        last;
        logic [31:0] length;
    } cmd_t;

    // Request and response of the shared multiply unit.
    typedef struct packed {
        logic        start;
        logic [63:0] operand;
    } mul_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] product;
    } mul_rsp_t;

    // Steps of the multiply unit.
    typedef enum logic [2:0] {
        MUL_IDLE,
        MUL_LOLO,
        MUL_LOHI,
        MUL_HILO,
        MUL_SUM
    } mul_step_t;

    // States of the back-end sequencer.
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SEED,
        BK_BODY,
        BK_KEY1,
        BK_KEY2,
        BK_HMUL,
        BK_CHECK,
        BK_FIN,
        BK_EMIT
    } back_state_t;

    // Mask that keeps the low count bytes of a word.
    function automatic logic [63:0] tail_mask(input logic [3:0] count);
        logic [63:0] mask;
        mask = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < count)
            begin
                mask[i*8 +: 8] = 8'hff;
            end
        end
        return mask;
    endfunction

endpackage

>>> rtl/mm64_if.sv
`timescale 1ns / 1ps

// Input word channel.
interface mm64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        first_word;
    logic        last_word;
    logic [31:0] message_length;

    modport source (
        output valid, data_word, byte_count, first_word, last_word, message_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_word, last_word, message_length,
        output ready
    );
endinterface

// Result channel.
interface mm64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic        length_mismatch;

    modport source (
        output valid, hash_value, length_mismatch,
        input  ready
    );
    modport sink (
        input  valid, hash_value, length_mismatch,
        output ready
    );
endinterface

// Seed register write channel.
interface mm64_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_seed;

    modport source (
        output valid, hash_seed,
        input  ready
    );
    modport sink (
        input  valid, hash_seed,
        output ready
    );
endinterface

>>> rtl/mm64_queue.sv
`timescale 1ns / 1ps

module mm64_queue #(
    parameter int unsigned QueueDepth = mm64_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  mm64_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output mm64_pkg::cmd_t  head_cmd,
    output logic            empty
);

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);
    localparam logic [CntW-1:0] FullCount = CntW'(QueueDepth);

    mm64_pkg::cmd_t  slot_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == FullCount);
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and fill count updates with wrap at the last slot.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/mm64_front.sv
`timescale 1ns / 1ps

module mm64_front (
    mm64_in_if.sink         in_chan,
    input  logic            queue_full,
    output logic            push,
    output mm64_pkg::cmd_t  push_cmd
);

    logic [3:0] count_clamped;

    // Counts above eight act as a full word.
    assign count_clamped = (in_chan.byte_count > mm64_pkg::WORD_BYTES) ?
                           mm64_pkg::WORD_BYTES : in_chan.byte_count;

    // A transaction is taken whenever the queue has room.
    assign in_chan.ready = !queue_full;
    assign push          = in_chan.valid && !queue_full;

    // Classify the word and strip the bytes past the count of a tail word.
    always_comb
    begin
        push_cmd.count  = count_clamped;
        push_cmd.first  = in_chan.first_word;
        push_cmd.last   = in_chan.last_word;
        push_cmd.length = in_chan.message_length;
        if (count_clamped == mm64_pkg::WORD_BYTES)
        begin
            push_cmd.kind = mm64_pkg::KIND_FULL;
            push_cmd.word = in_chan.data_word;
        end
        else if (count_clamped == '0)
        begin
            push_cmd.kind = mm64_pkg::KIND_SKIP;
            push_cmd.word = in_chan.data_word;
        end
        else
        begin
            push_cmd.kind = mm64_pkg::KIND_TAIL;
            push_cmd.word = in_chan.data_word & mm64_pkg::tail_mask(count_clamped);
        end
    end

endmodule

>>> rtl/mm64_mul.sv
`timescale 1ns / 1ps

module mm64_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  mm64_pkg::mul_req_t req,
    output mm64_pkg::mul_rsp_t rsp
);

    mm64_pkg::mul_step_t state_reg;
    mm64_pkg::mul_step_t state_next;
    logic [63:0] operand_reg;
    logic [63:0] partial_reg;
    logic [31:0] cross_reg;
    logic [63:0] product_reg;
    logic        done_reg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // Step sequence: low by low, the two cross terms, then the final sum.
    always_comb
    begin
        case (state_reg)
            mm64_pkg::MUL_IDLE: state_next = req.start ? mm64_pkg::MUL_LOLO : mm64_pkg::MUL_IDLE;
            mm64_pkg::MUL_LOLO: state_next = mm64_pkg::MUL_LOHI;
            mm64_pkg::MUL_LOHI: state_next = mm64_pkg::MUL_HILO;
            mm64_pkg::MUL_HILO: state_next = mm64_pkg::MUL_SUM;
            mm64_pkg::MUL_SUM:  state_next = mm64_pkg::MUL_IDLE;
            default:            state_next = mm64_pkg::MUL_IDLE;
        endcase
    end

    // Operand selection for the one shared 32x32 multiplier.
    always_comb
    begin
        case (state_reg)
            mm64_pkg::MUL_LOHI:
            begin
                mul_a = operand_reg[31:0];
                mul_b = mm64_pkg::MIX_MUL_HI;
            end
            mm64_pkg::MUL_HILO:
            begin
                mul_a = operand_reg[63:32];
                mul_b = mm64_pkg::MIX_MUL_LO;
            end
            default:
            begin
                mul_a = operand_reg[31:0];
                mul_b = mm64_pkg::MIX_MUL_LO;
            end
        endcase
    end

    assign mul_p = {32'h0, mul_a} * {32'h0, mul_b};

    assign rsp.done    = done_reg;
    assign rsp.product = product_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm64_pkg::MUL_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == mm64_pkg::MUL_SUM);
        end
    end

    // Partial products; only the low 64 bits of the full product are kept.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            mm64_pkg::MUL_IDLE:
            begin
                if (req.start)
                begin
                    operand_reg <= req.operand;
                end
            end
            mm64_pkg::MUL_LOLO: partial_reg <= mul_p;
            mm64_pkg::MUL_LOHI: cross_reg   <= mul_p[31:0];
            mm64_pkg::MUL_HILO: cross_reg   <= cross_reg + mul_p[31:0];
            mm64_pkg::MUL_SUM:  product_reg <= partial_reg + {cross_reg, 32'h0};
            default:
            begin
                operand_reg <= operand_reg;
            end
        endcase
    end

endmodule

>>> rtl/mm64_back.sv
`timescale 1ns / 1ps

module mm64_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [63:0]        hash_seed,
    input  logic               queue_empty,
    input  mm64_pkg::cmd_t     head_cmd,
    output logic               pop,
    output mm64_pkg::mul_req_t mul_req,
    input  mm64_pkg::mul_rsp_t mul_rsp,
    mm64_out_if.source         out_chan
);

    mm64_pkg::back_state_t state_reg;
    mm64_pkg::back_state_t state_next;
    mm64_pkg::cmd_t cmd_reg;
    mm64_pkg::cmd_t cmd_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;
    logic [31:0] expected_reg;
    logic [31:0] expected_next;
    logic [31:0] received_reg;
    logic [31:0] received_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] out_hash_reg;
    logic [63:0] out_hash_next;
    logic        out_mismatch_reg;
    logic        out_mismatch_next;
    logic        out_free;
    logic [63:0] prod;

    assign prod     = mul_rsp.product;
    assign out_free = !out_valid_reg || out_chan.ready;

    assign out_chan.valid           = out_valid_reg;
    assign out_chan.hash_value      = out_hash_reg;
    assign out_chan.length_mismatch = out_mismatch_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm64_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = head_cmd.first ? mm64_pkg::BK_SEED : mm64_pkg::BK_BODY;
                end
            end
            mm64_pkg::BK_SEED:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mm64_pkg::BK_BODY;
                end
            end
            mm64_pkg::BK_BODY:
            begin
                case (cmd_reg.kind)
                    mm64_pkg::KIND_FULL: state_next = mm64_pkg::BK_KEY1;
                    mm64_pkg::KIND_TAIL: state_next = mm64_pkg::BK_HMUL;
                    default:             state_next = mm64_pkg::BK_CHECK;
                endcase
            end
            mm64_pkg::BK_KEY1:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mm64_pkg::BK_KEY2;
                end
            end
            mm64_pkg::BK_KEY2:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mm64_pkg::BK_HMUL;
                end
            end
            mm64_pkg::BK_HMUL:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mm64_pkg::BK_CHECK;
                end
            end
            mm64_pkg::BK_CHECK:
            begin
                state_next = cmd_reg.last ? mm64_pkg::BK_FIN : mm64_pkg::BK_IDLE;
            end
            mm64_pkg::BK_FIN:
            begin
                if (mul_rsp.done)
                begin
                    state_next = mm64_pkg::BK_EMIT;
                end
            end
            mm64_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mm64_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = mm64_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath, multiply requests and the result register.
    always_comb
    begin
        pop               = 1'b0;
        mul_req.start     = 1'b0;
        mul_req.operand   = '0;
        cmd_next          = cmd_reg;
        hash_next         = hash_reg;
        expected_next     = expected_reg;
        received_next     = received_reg;
        out_valid_next    = out_valid_reg && !out_chan.ready;
        out_hash_next     = out_hash_reg;
        out_mismatch_next = out_mismatch_reg;
        case (state_reg)
            mm64_pkg::BK_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    // A first word starts with length times the constant.
                    if (head_cmd.first)
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = {32'h0, head_cmd.length};
                    end
                end
            end
            mm64_pkg::BK_SEED:
            begin
                if (mul_rsp.done)
                begin
                    hash_next     = hash_seed ^ prod;
                    expected_next = cmd_reg.length;
                    received_next = '0;
                end
            end
            mm64_pkg::BK_BODY:
            begin
                received_next = received_reg + {28'h0, cmd_reg.count};
                case (cmd_reg.kind)
                    mm64_pkg::KIND_FULL:
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = cmd_reg.word;
                    end
                    mm64_pkg::KIND_TAIL:
                    begin
                        mul_req.start   = 1'b1;
                        mul_req.operand = hash_reg ^ cmd_reg.word;
                    end
                    default:
                    begin
                        mul_req.start = 1'b0;
                    end
                endcase
            end
            mm64_pkg::BK_KEY1:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = prod ^ (prod >> mm64_pkg::MIX_SHIFT);
                end
            end
            mm64_pkg::BK_KEY2:
            begin
                if (mul_rsp.done)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = hash_reg ^ prod;
                end
            end
            mm64_pkg::BK_HMUL:
            begin
                if (mul_rsp.done)
                begin
                    hash_next = prod;
                end
            end
            mm64_pkg::BK_CHECK:
            begin
                // The running hash stays; the finalizer works on a copy.
                if (cmd_reg.last)
                begin
                    mul_req.start   = 1'b1;
                    mul_req.operand = hash_reg ^ (hash_reg >> mm64_pkg::MIX_SHIFT);
                end
            end
            mm64_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    out_hash_next     = prod ^ (prod >> mm64_pkg::MIX_SHIFT);
                    out_mismatch_next = (received_reg != expected_reg);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mm64_pkg::BK_IDLE;
            hash_reg      <= '0;
            expected_reg  <= '0;
            received_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            expected_reg  <= expected_next;
            received_reg  <= received_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        out_hash_reg     <= out_hash_next;
        out_mismatch_reg <= out_mismatch_next;
    end

endmodule

>>> rtl/murmur64a_hash_stream_core.sv
`timescale 1ns / 1ps

// MurmurHash64A over a stream of little-endian 64-bit message words.
// Channels: in_chan takes one word per transaction with its byte count and
// first/last marks; the first word also carries the message length.
// out_chan gives one transaction per message, on its last word: the hash
// and a flag set when the counted bytes differ from the announced length.
// cfg_chan writes the 64-bit seed; it is always ready. The user must write
// it only while no message is in flight; the block does not enforce this.
// Datapath: every 64-bit multiply runs on one shared 32x32 multiplier in
// three partial products plus a sum. A full word runs the key, remixed-key
// and hash multiplies in the back end, a tail word only the hash multiply,
// an empty word none; a first word adds the seed multiply and a last word
// the finalizer multiply.
// A small command queue takes new words while the back end is busy.
// A stalled receiver holds the result register; the back end then waits
// before it overwrites it, and the queue fills until input ready drops.
// Reset clears the seed, the running hash, both byte counters and the queue.
module murmur64a_hash_stream_core #(
    parameter int unsigned QueueDepth = mm64_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    mm64_cfg_if.sink    cfg_chan,
    mm64_in_if.sink     in_chan,
    mm64_out_if.source  out_chan
);

    logic               push;
    mm64_pkg::cmd_t     push_cmd;
    logic               queue_full;
    logic               queue_empty;
    logic               pop;
    mm64_pkg::cmd_t     head_cmd;
    mm64_pkg::mul_req_t mul_req;
    mm64_pkg::mul_rsp_t mul_rsp;
    logic [63:0]        seed_reg;

    // Seed register write.
    assign cfg_chan.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_chan.valid)
        begin
            seed_reg <= cfg_chan.hash_seed;
        end
    end

    // Front end: accept and classify words.
    mm64_front u_front (
        .in_chan    (in_chan),
        .queue_full (queue_full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue between the two halves.
    mm64_queue #(
        .QueueDepth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (queue_empty)
    );

    // Shared multiply by the mixing constant.
    mm64_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Back end: hash sequencer and result register.
    mm64_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .hash_seed   (seed_reg),
        .queue_empty (queue_empty),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .mul_req     (mul_req),
        .mul_rsp     (mul_rsp),
        .out_chan    (out_chan)
    );

endmodule

>>> rtl/mm64_checker.sv
`timescale 1ns / 1ps

module mm64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] out_hash_value,
    input logic        out_length_mismatch
);

    // The seed port never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("seed write channel not ready");

    // No result is pending right after reset.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // A result waiting on the receiver stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn before transaction");

    // A result waiting on the receiver keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(out_hash_value) && $stable(out_length_mismatch)))
        else $error("result changed while stalled");

endmodule

bind murmur64a_hash_stream_core mm64_checker u_mm64_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_ready           (cfg_chan.ready),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_hash_value      (out_chan.hash_value),
    .out_length_mismatch (out_chan.length_mismatch)
);
